/* sv/swm_pkg.sv */
`timescale 1ns / 1ps

package swm_pkg;

	// Sample and result field widths.
	localparam int SAMPLE_W  = 8;
	localparam int SSIM_W    = 16;
	localparam int ROW_W     = 12;
	localparam int COL_OUT_W = 11;
	localparam int IWIDTH_W  = 12;
	localparam int IHEIGHT_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;

	// Frame limits and defaults.
	localparam int MAX_HEIGHT     = 4096;
	localparam int WIDTH_DEFAULT  = 640;
	localparam int HEIGHT_DEFAULT = 480;

	// Stabilizers, scaled by 4096.
	localparam int STAB1 = 26634;
	localparam int STAB2 = 239708;

	// One in Q2.14 and the number of quotient bits a divide produces.
	localparam int SSIM_ONE = 16384;
	localparam int QSTEPS   = 15;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	// Sequencer states.
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_PROD  = 10'b00_0000_0010,
		ST_WR    = 10'b00_0000_0100,
		ST_SUB   = 10'b00_0000_1000,
		ST_MUL   = 10'b00_0001_0000,
		ST_TERMS = 10'b00_0010_0000,
		ST_DIV   = 10'b00_0100_0000,
		ST_FIN   = 10'b00_1000_0000,
		ST_MEAN  = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	// Which product the serial multiplier is working on.
	typedef enum logic [2:0] {
		MUL_SS  = 3'd0,
		MUL_S11 = 3'd1,
		MUL_S22 = 3'd2,
		MUL_AB  = 3'd3,
		MUL_CD  = 3'd4
	} mul_sel_t;

endpackage

/* sv/swm_ram.sv */
`timescale 1ns / 1ps

module swm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/ssim_window_metric.sv */
`timescale 1ns / 1ps
// Sequence: a pixel that completes no window passes PROD, WR and SUB and returns to idle.
// A window result then runs five shift-add products (each ends once its multiplier operand is
// shifted out), a term step, the bit-serial divide, FIN and OUT; the last window of a frame
// adds the mean divide before OUT.
// Throughput is one request at a time, set by the serial multiplier and one-bit divider.
// Reset clears control, counters, window sums and configuration; memories and datapath are not.

module ssim_window_metric #(
	parameter int WINDOW    = 8,
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [swm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swm_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	// Sample pairs: [7:0] src_sample, [15:8] dst_sample.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,
	// Results: [15:0] ssim_q14, [27:16] window_row, [38:28] window_col,
	// [54:39] mean_ssim_q14, [55] zero.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [55:0]                     m_tdata,
	// last_window.
	output logic                            m_tlast
);

	localparam int NN   = WINDOW * WINDOW;
	localparam int LN   = $clog2(NN);
	localparam int TW   = 30 + 2 * LN;
	localparam int TW1  = TW + 1;
	localparam int PW   = 2 * TW;
	localparam int DW   = PW + 16;
	localparam int CLW  = $clog2(WINDOW * 255 + 1);
	localparam int CQW  = $clog2(WINDOW * 65025 + 1);
	localparam int SW   = $clog2(NN * 255 + 1);
	localparam int QW   = $clog2(NN * 65025 + 1);
	localparam int PSW  = 2 * SW;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int RMW  = $clog2(WINDOW);
	localparam int RSD  = WINDOW * MAX_WIDTH;
	localparam int RSAW = $clog2(RSD);
	localparam int CNTW = $clog2(MAX_WIDTH * swm_pkg::MAX_HEIGHT + 1);
	localparam int TOTW = CNTW + 16;
	localparam longint C1N = longint'(swm_pkg::STAB1) * NN * NN;
	localparam longint C2N = longint'(swm_pkg::STAB2) * NN * NN;

	typedef struct packed {
		logic [CQW-1:0] x;
		logic [CQW-1:0] q2;
		logic [CQW-1:0] q1;
		logic [CLW-1:0] l2;
		logic [CLW-1:0] l1;
	} colsum_t;

	localparam int CRW = $bits(colsum_t);

	swm_pkg::state_t   state_q;
	swm_pkg::mul_sel_t mul_sel_q;

	logic [swm_pkg::IWIDTH_W-1:0]  image_width_q;
	logic [swm_pkg::IHEIGHT_W-1:0] image_height_q;
	logic [swm_pkg::ROW_W-1:0]     pixel_row_q, cur_row_q;
	logic [CW-1:0]                 pixel_col_q, cur_col_q;
	logic [RMW-1:0]                row_mod_q, cur_rm_q;
	logic [TOTW-1:0]               tot_q;

	logic [7:0]  s_q, d_q, os_q, od_q;
	logic [15:0] pss_q, pdd_q, psd_q, poss_q, podd_q, posd_q;

	logic [SW-1:0] ws1_q, ws2_q;
	logic [QW-1:0] wq1_q, wq2_q, wx_q;
	logic [SW-1:0] ws1_n, ws2_n;
	logic [QW-1:0] wq1_n, wq2_n, wx_n;

	logic [PW-1:0]  mul_x_q, mul_acc_q;
	logic [TW-1:0]  mul_y_q;
	logic [PSW-1:0] p_ss_q, p11_q, p22_q;
	logic [TW-1:0]  c_q, d_term_q;
	logic           bneg_q;
	logic [PW-1:0]  ab_q, cd_q;
	logic [CNTW-1:0] cnt_q;

	logic [DW-1:0]   div_rem_q, div_dsh_q;
	logic [14:0]     div_q_q;
	logic [TOTW-1:0] mrem_q, mdsh_q;
	logic [14:0]     mq_q;
	logic            mneg_q;
	logic [3:0]      step_q;

	logic [swm_pkg::SSIM_W-1:0] ssim_q;
	logic                       last_q;

	logic                           m_tvalid_q;
	logic [swm_pkg::SSIM_W-1:0]     out_ssim_q, out_mean_q;
	logic [swm_pkg::ROW_W-1:0]      out_row_q;
	logic [swm_pkg::COL_OUT_W-1:0]  out_col_q;
	logic                           out_last_q;

	// Clamped frame size.
	logic [WW-1:0]                 wc;
	logic [swm_pkg::IHEIGHT_W-1:0] hc;

	always_comb begin
		if (image_width_q < WINDOW) begin
			wc = WW'(WINDOW);
		end else if (image_width_q > MAX_WIDTH) begin
			wc = WW'(MAX_WIDTH);
		end else begin
			wc = WW'(image_width_q);
		end
		if (image_height_q < WINDOW) begin
			hc = swm_pkg::IHEIGHT_W'(WINDOW);
		end else if (image_height_q > swm_pkg::MAX_HEIGHT) begin
			hc = swm_pkg::IHEIGHT_W'(swm_pkg::MAX_HEIGHT);
		end else begin
			hc = image_height_q;
		end
	end

	// Position of the pixel being requested and the position after it.
	logic [swm_pkg::ROW_W-1:0]     acc_row, nxt_row;
	logic [CW-1:0]                 acc_col, nxt_col;
	logic [RMW-1:0]                acc_rm, nxt_rm;
	logic [WW-1:0]                 col_inc;
	logic [swm_pkg::IHEIGHT_W-1:0] row_inc;

	always_comb begin
		if ({1'b0, pixel_row_q} >= hc) begin
			acc_row = '0;
			acc_rm  = '0;
		end else begin
			acc_row = pixel_row_q;
			acc_rm  = row_mod_q;
		end
		acc_col = (WW'(pixel_col_q) >= wc) ? '0 : pixel_col_q;
		col_inc = WW'(acc_col) + WW'(1);
		row_inc = swm_pkg::IHEIGHT_W'(acc_row) + swm_pkg::IHEIGHT_W'(1);
		nxt_row = acc_row;
		nxt_rm  = acc_rm;
		nxt_col = CW'(col_inc);
		if (col_inc >= wc) begin
			nxt_col = '0;
			if (row_inc >= hc) begin
				nxt_row = '0;
				nxt_rm  = '0;
			end else begin
				nxt_row = row_inc[swm_pkg::ROW_W-1:0];
				nxt_rm  = (acc_rm == RMW'(WINDOW - 1)) ? '0 : acc_rm + RMW'(1);
			end
		end
	end

	// Memories: the last rows of samples and the per-column sums.
	logic            accept;
	logic            row_we, row_re;
	logic [RSAW-1:0] row_waddr, row_raddr;
	logic [15:0]     row_rdata;
	logic            col_we, col_re;
	logic [CW-1:0]   col_waddr, col_raddr;
	colsum_t         col_wdata, col_rdata;

	// A register write takes the cycle, so no request is taken along with it.
	assign accept = (state_q == swm_pkg::ST_IDLE) && s_tvalid && !cfg_we;

	swm_ram #(.WIDTH(16), .DEPTH(RSD)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata ({s_q, d_q}),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	swm_ram #(.WIDTH(CRW), .DEPTH(MAX_WIDTH)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.re    (col_re),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	// Column update, memory ports and the window sums after the oldest column leaves.
	always_comb begin
		row_we    = (state_q == swm_pkg::ST_WR);
		row_waddr = RSAW'(cur_rm_q) * RSAW'(MAX_WIDTH) + RSAW'(cur_col_q);
		row_re    = accept;
		row_raddr = RSAW'(acc_rm) * RSAW'(MAX_WIDTH) + RSAW'(acc_col);

		if (cur_row_q == '0) begin
			col_wdata.l1 = CLW'(s_q);
			col_wdata.l2 = CLW'(d_q);
			col_wdata.q1 = CQW'(pss_q);
			col_wdata.q2 = CQW'(pdd_q);
			col_wdata.x  = CQW'(psd_q);
		end else begin
			col_wdata.l1 = col_rdata.l1 + CLW'(s_q) - CLW'(os_q);
			col_wdata.l2 = col_rdata.l2 + CLW'(d_q) - CLW'(od_q);
			col_wdata.q1 = col_rdata.q1 + CQW'(pss_q) - CQW'(poss_q);
			col_wdata.q2 = col_rdata.q2 + CQW'(pdd_q) - CQW'(podd_q);
			col_wdata.x  = col_rdata.x + CQW'(psd_q) - CQW'(posd_q);
		end
		col_we    = (state_q == swm_pkg::ST_WR);
		col_waddr = cur_col_q;
		col_re    = accept || ((state_q == swm_pkg::ST_WR) && (cur_col_q >= WINDOW));
		col_raddr = accept ? acc_col : cur_col_q - CW'(WINDOW);

		ws1_n = ws1_q;
		ws2_n = ws2_q;
		wq1_n = wq1_q;
		wq2_n = wq2_q;
		wx_n  = wx_q;
		if (cur_col_q >= WINDOW) begin
			ws1_n = ws1_q - SW'(col_rdata.l1);
			ws2_n = ws2_q - SW'(col_rdata.l2);
			wq1_n = wq1_q - QW'(col_rdata.q1);
			wq2_n = wq2_q - QW'(col_rdata.q2);
			wx_n  = wx_q - QW'(col_rdata.x);
		end
	end

	// SSIM terms from the window sums and the squared sums.
	logic [TW-1:0]  t_a, t_c, t_d, t_bmag;
	logic [TW1-1:0] t_bs;

	always_comb begin
		t_a  = (TW'(p_ss_q) << 13) + TW'(C1N);
		t_bs = ((TW1'(NN) * TW1'(wx_q) - TW1'(p_ss_q)) << 13) + TW1'(C2N);
		t_c  = ((TW'(p11_q) + TW'(p22_q)) << 12) + TW'(C1N);
		t_d  = ((TW'(NN) * TW'(wq1_q) - TW'(p11_q) + TW'(NN) * TW'(wq2_q) - TW'(p22_q))
			<< 12) + TW'(C2N);
		t_bmag = t_bs[TW] ? TW'(-t_bs) : t_bs[TW-1:0];
	end

	// Rounded quotient, running total and last-window test.
	logic [14:0]                qc;
	logic [swm_pkg::SSIM_W-1:0] fin_ssim, fin_mean;
	logic [TOTW-1:0]            fin_tot;
	logic                       fin_last;

	always_comb begin
		qc       = (div_q_q > 15'(swm_pkg::SSIM_ONE)) ? 15'(swm_pkg::SSIM_ONE) : div_q_q;
		fin_ssim = bneg_q ? -{1'b0, qc} : {1'b0, qc};
		fin_tot  = tot_q + {{(TOTW - swm_pkg::SSIM_W){fin_ssim[swm_pkg::SSIM_W-1]}}, fin_ssim};
		fin_last = ({1'b0, cur_row_q} == hc - swm_pkg::IHEIGHT_W'(1)) &&
			(WW'(cur_col_q) == wc - WW'(1));
		fin_mean = mneg_q ? -{1'b0, mq_q} : {1'b0, mq_q};
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= swm_pkg::ST_IDLE;
			image_width_q  <= swm_pkg::IWIDTH_W'(swm_pkg::WIDTH_DEFAULT);
			image_height_q <= swm_pkg::IHEIGHT_W'(swm_pkg::HEIGHT_DEFAULT);
			pixel_row_q    <= '0;
			pixel_col_q    <= '0;
			row_mod_q      <= '0;
			tot_q          <= '0;
			ws1_q          <= '0;
			ws2_q          <= '0;
			wq1_q          <= '0;
			wq2_q          <= '0;
			wx_q           <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			// The output register empties unless a new result refills it below.
			if (m_tvalid_q && m_tready && (state_q != swm_pkg::ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				swm_pkg::ST_IDLE: begin
					if (accept) begin
						s_q         <= s_tdata[7:0];
						d_q         <= s_tdata[15:8];
						cur_row_q   <= acc_row;
						cur_col_q   <= acc_col;
						cur_rm_q    <= acc_rm;
						pixel_row_q <= nxt_row;
						pixel_col_q <= nxt_col;
						row_mod_q   <= nxt_rm;
						state_q     <= swm_pkg::ST_PROD;
					end
				end
				swm_pkg::ST_PROD: begin
					// The stored row only leaves the column once it is WINDOW rows old.
					if (cur_row_q >= WINDOW) begin
						os_q   <= row_rdata[15:8];
						od_q   <= row_rdata[7:0];
						poss_q <= row_rdata[15:8] * row_rdata[15:8];
						podd_q <= row_rdata[7:0] * row_rdata[7:0];
						posd_q <= row_rdata[15:8] * row_rdata[7:0];
					end else begin
						os_q   <= '0;
						od_q   <= '0;
						poss_q <= '0;
						podd_q <= '0;
						posd_q <= '0;
					end
					pss_q   <= s_q * s_q;
					pdd_q   <= d_q * d_q;
					psd_q   <= s_q * d_q;
					state_q <= swm_pkg::ST_WR;
				end
				swm_pkg::ST_WR: begin
					if (cur_col_q == '0) begin
						ws1_q <= SW'(col_wdata.l1);
						ws2_q <= SW'(col_wdata.l2);
						wq1_q <= QW'(col_wdata.q1);
						wq2_q <= QW'(col_wdata.q2);
						wx_q  <= QW'(col_wdata.x);
					end else begin
						ws1_q <= ws1_q + SW'(col_wdata.l1);
						ws2_q <= ws2_q + SW'(col_wdata.l2);
						wq1_q <= wq1_q + QW'(col_wdata.q1);
						wq2_q <= wq2_q + QW'(col_wdata.q2);
						wx_q  <= wx_q + QW'(col_wdata.x);
					end
					state_q <= swm_pkg::ST_SUB;
				end
				swm_pkg::ST_SUB: begin
					ws1_q <= ws1_n;
					ws2_q <= ws2_n;
					wq1_q <= wq1_n;
					wq2_q <= wq2_n;
					wx_q  <= wx_n;
					if ((cur_row_q >= WINDOW - 1) && (cur_col_q >= WINDOW - 1)) begin
						mul_x_q   <= PW'(ws1_n);
						mul_y_q   <= TW'(ws2_n);
						mul_acc_q <= '0;
						mul_sel_q <= swm_pkg::MUL_SS;
						state_q   <= swm_pkg::ST_MUL;
					end else begin
						state_q <= swm_pkg::ST_IDLE;
					end
				end
				swm_pkg::ST_MUL: begin
					if (mul_y_q == '0) begin
						mul_acc_q <= '0;
						case (mul_sel_q)
							swm_pkg::MUL_SS: begin
								p_ss_q    <= PSW'(mul_acc_q);
								mul_x_q   <= PW'(ws1_q);
								mul_y_q   <= TW'(ws1_q);
								mul_sel_q <= swm_pkg::MUL_S11;
							end
							swm_pkg::MUL_S11: begin
								p11_q     <= PSW'(mul_acc_q);
								mul_x_q   <= PW'(ws2_q);
								mul_y_q   <= TW'(ws2_q);
								mul_sel_q <= swm_pkg::MUL_S22;
							end
							swm_pkg::MUL_S22: begin
								p22_q   <= PSW'(mul_acc_q);
								state_q <= swm_pkg::ST_TERMS;
							end
							swm_pkg::MUL_AB: begin
								ab_q      <= mul_acc_q;
								mul_x_q   <= PW'(c_q);
								mul_y_q   <= d_term_q;
								mul_sel_q <= swm_pkg::MUL_CD;
							end
							swm_pkg::MUL_CD: begin
								cd_q      <= mul_acc_q;
								div_rem_q <= (DW'(ab_q) << 15) + DW'(mul_acc_q);
								div_dsh_q <= DW'(mul_acc_q) << 15;
								div_q_q   <= '0;
								step_q    <= '0;
								state_q   <= swm_pkg::ST_DIV;
							end
							default: begin
								state_q <= swm_pkg::ST_IDLE;
							end
						endcase
					end else begin
						if (mul_y_q[0]) begin
							mul_acc_q <= mul_acc_q + mul_x_q;
						end
						mul_x_q <= mul_x_q << 1;
						mul_y_q <= mul_y_q >> 1;
					end
				end
				swm_pkg::ST_TERMS: begin
					c_q       <= t_c;
					d_term_q  <= t_d;
					bneg_q    <= t_bs[TW];
					cnt_q     <= CNTW'((int'(wc) - WINDOW + 1) * (int'(hc) - WINDOW + 1));
					mul_x_q   <= PW'(t_a);
					mul_y_q   <= t_bmag;
					mul_acc_q <= '0;
					mul_sel_q <= swm_pkg::MUL_AB;
					state_q   <= swm_pkg::ST_MUL;
				end
				swm_pkg::ST_DIV: begin
					// One quotient bit per cycle against 2*C*D.
					if (div_rem_q >= div_dsh_q) begin
						div_rem_q <= div_rem_q - div_dsh_q;
						div_q_q   <= {div_q_q[13:0], 1'b1};
					end else begin
						div_q_q <= {div_q_q[13:0], 1'b0};
					end
					div_dsh_q <= div_dsh_q >> 1;
					step_q    <= step_q + 4'd1;
					if (step_q == 4'(swm_pkg::QSTEPS - 1)) begin
						state_q <= swm_pkg::ST_FIN;
					end
				end
				swm_pkg::ST_FIN: begin
					ssim_q <= fin_ssim;
					last_q <= fin_last;
					if (fin_last) begin
						tot_q   <= '0;
						mneg_q  <= fin_tot[TOTW-1];
						mrem_q  <= fin_tot[TOTW-1] ? -fin_tot : fin_tot;
						mdsh_q  <= TOTW'(cnt_q) << 14;
						mq_q    <= '0;
						step_q  <= '0;
						state_q <= swm_pkg::ST_MEAN;
					end else begin
						tot_q   <= fin_tot;
						state_q <= swm_pkg::ST_OUT;
					end
				end
				swm_pkg::ST_MEAN: begin
					// Frame mean, truncated toward zero.
					if (mrem_q >= mdsh_q) begin
						mrem_q <= mrem_q - mdsh_q;
						mq_q   <= {mq_q[13:0], 1'b1};
					end else begin
						mq_q <= {mq_q[13:0], 1'b0};
					end
					mdsh_q <= mdsh_q >> 1;
					step_q <= step_q + 4'd1;
					if (step_q == 4'(swm_pkg::QSTEPS - 1)) begin
						state_q <= swm_pkg::ST_OUT;
					end
				end
				swm_pkg::ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_ssim_q <= ssim_q;
						out_row_q  <= cur_row_q - swm_pkg::ROW_W'(WINDOW - 1);
						out_col_q  <= swm_pkg::COL_OUT_W'(CW'(cur_col_q - CW'(WINDOW - 1)));
						out_last_q <= last_q;
						out_mean_q <= last_q ? fin_mean : '0;
						state_q    <= swm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= swm_pkg::ST_IDLE;
				end
			endcase
			// A write to the width or height register restarts the frame.
			if (cfg_we) begin
				case (cfg_index)
					swm_pkg::CFG_WIDTH: begin
						image_width_q <= cfg_wdata[swm_pkg::IWIDTH_W-1:0];
						pixel_row_q   <= '0;
						pixel_col_q   <= '0;
						row_mod_q     <= '0;
						tot_q         <= '0;
					end
					swm_pkg::CFG_HEIGHT: begin
						image_height_q <= cfg_wdata;
						pixel_row_q    <= '0;
						pixel_col_q    <= '0;
						row_mod_q      <= '0;
						tot_q          <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign s_tready = (state_q == swm_pkg::ST_IDLE) && !cfg_we;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_mean_q, out_col_q, out_row_q, out_ssim_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	// The divisor of the SSIM quotient is never zero.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swm_pkg::ST_DIV) |-> (cd_q != '0))
		else $error("SSIM divisor is zero");

	// A finished window value lies within plus and minus one.
	a_ssim_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swm_pkg::ST_OUT) |->
		(($signed(ssim_q) <= 16'sd16384) && ($signed(ssim_q) >= -16'sd16384)))
		else $error("window SSIM out of range");

	// The column store never reads the entry it writes in the same cycle.
	a_col_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(col_we && col_re) |-> (col_waddr != col_raddr))
		else $error("column store read and write collide");
`endif

endmodule

/* sim/ssim_window_metric_tb.sv */
`timescale 1ns / 1ps

module ssim_window_metric_tb;

	localparam int WIN         = 8;
	localparam int MAXW        = 2048;
	localparam int WIN_AREA    = WIN * WIN;
	localparam int SETTLE      = 40;
	localparam int HOLD_CYCLES = 1500;
	localparam int ITEM_COUNT  = 1050;
	localparam logic [swm_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [swm_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// Sample content patterns used to build frames.
	typedef enum int {PAT_RANDOM, PAT_SAME, PAT_INVERT, PAT_NOISY, PAT_FLAT} pattern_t;

	typedef struct packed {
		logic signed [swm_pkg::SSIM_W-1:0] ssim;
		logic [swm_pkg::ROW_W-1:0]         row;
		logic [swm_pkg::COL_OUT_W-1:0]     col;
		logic                              last;
		logic signed [swm_pkg::SSIM_W-1:0] mean;
	} window_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [swm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [swm_pkg::CFG_DAT_W-1:0] cfg_wdata;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [15:0]                   s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [55:0]                   m_tdata;
	logic                          m_tlast;

	ssim_window_metric uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// Predictor state: registers, stored samples, column and window sums.
	int unsigned    reg_width;
	int unsigned    reg_height;
	logic [15:0]    pair_store [WIN*MAXW];
	longint         col_src [MAXW];
	longint         col_dst [MAXW];
	longint         col_src_sq [MAXW];
	longint         col_dst_sq [MAXW];
	longint         col_cross [MAXW];
	longint         win_src, win_dst, win_src_sq, win_dst_sq, win_cross;
	int unsigned    at_row, at_col;
	longint         frame_ssim_sum;

	window_result_t pending_windows[$];
	int             mismatches;
	int             pairs_sent;
	int             hold_req;
	int             hold_seen;
	int             hold_left;
	bit             no_gaps;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Exact SSIM of the current window sums, rounded half away from zero.
	function automatic logic signed [swm_pkg::SSIM_W-1:0] window_quality();
		longint        n, nn, covn, bs;
		logic [127:0]  a, bmag, c, d, den, num, q;
		n    = WIN_AREA;
		nn   = n * n;
		a    = 8192 * win_src * win_dst + swm_pkg::STAB1 * nn;
		covn = n * win_cross - win_src * win_dst;
		bs   = 8192 * covn + swm_pkg::STAB2 * nn;
		bmag = (bs < 0) ? -bs : bs;
		c    = 4096 * (win_src * win_src + win_dst * win_dst) + swm_pkg::STAB1 * nn;
		d    = 4096 * (n * win_src_sq - win_src * win_src + n * win_dst_sq
			- win_dst * win_dst) + swm_pkg::STAB2 * nn;
		den  = c * d;
		num  = ((a * bmag) << 15) + den;
		q    = num / (den << 1);
		if (q > swm_pkg::SSIM_ONE)
			q = swm_pkg::SSIM_ONE;
		return (bs < 0) ? -q[swm_pkg::SSIM_W-1:0] : q[swm_pkg::SSIM_W-1:0];
	endfunction

	// Register write as the block sees it; any real write restarts the frame.
	function automatic void predict_write(logic [swm_pkg::CFG_IDX_W-1:0] idx,
			logic [swm_pkg::CFG_DAT_W-1:0] val);
		if (idx == swm_pkg::CFG_WIDTH)
			reg_width = val[swm_pkg::IWIDTH_W-1:0];
		else if (idx == swm_pkg::CFG_HEIGHT)
			reg_height = val[swm_pkg::IHEIGHT_W-1:0];
		else
			return;
		at_row = 0;
		at_col = 0;
		frame_ssim_sum = 0;
	endfunction

	// Advance the predictor by one sample pair; queue a result when a window closes.
	function automatic void predict_pair(logic [7:0] s, logic [7:0] d);
		int unsigned    w, h, row, col, slot, oc;
		longint         os, od;
		window_result_t r;
		w = (reg_width < WIN) ? WIN : ((reg_width > MAXW) ? MAXW : reg_width);
		h = (reg_height < WIN) ? WIN :
			((reg_height > swm_pkg::MAX_HEIGHT) ? swm_pkg::MAX_HEIGHT : reg_height);
		row = (at_row >= h) ? 0 : at_row;
		col = (at_col >= w) ? 0 : at_col;
		slot = (row % WIN) * MAXW + col;
		os = 0;
		od = 0;
		if (row >= WIN) begin
			os = pair_store[slot][15:8];
			od = pair_store[slot][7:0];
		end
		if (row == 0) begin
			col_src[col] = s;
			col_dst[col] = d;
			col_src_sq[col] = s * s;
			col_dst_sq[col] = d * d;
			col_cross[col] = s * d;
		end else begin
			col_src[col] += s - os;
			col_dst[col] += d - od;
			col_src_sq[col] += longint'(s) * s - os * os;
			col_dst_sq[col] += longint'(d) * d - od * od;
			col_cross[col] += longint'(s) * d - os * od;
		end
		pair_store[slot] = {s, d};
		if (col == 0) begin
			win_src = 0; win_dst = 0; win_src_sq = 0; win_dst_sq = 0; win_cross = 0;
		end
		win_src += col_src[col];
		win_dst += col_dst[col];
		win_src_sq += col_src_sq[col];
		win_dst_sq += col_dst_sq[col];
		win_cross += col_cross[col];
		if (col >= WIN) begin
			oc = col - WIN;
			win_src -= col_src[oc];
			win_dst -= col_dst[oc];
			win_src_sq -= col_src_sq[oc];
			win_dst_sq -= col_dst_sq[oc];
			win_cross -= col_cross[oc];
		end
		if (row >= WIN - 1 && col >= WIN - 1) begin
			r.ssim = window_quality();
			r.row = swm_pkg::ROW_W'(row - (WIN - 1));
			r.col = swm_pkg::COL_OUT_W'(col - (WIN - 1));
			r.last = (row == h - 1) && (col == w - 1);
			r.mean = '0;
			frame_ssim_sum += r.ssim;
			if (r.last) begin
				r.mean = swm_pkg::SSIM_W'(frame_ssim_sum /
					(longint'(w - WIN + 1) * longint'(h - WIN + 1)));
				frame_ssim_sum = 0;
			end
			pending_windows.push_back(r);
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h) begin
				row = 0;
				frame_ssim_sum = 0;
			end
		end
		at_row = row;
		at_col = col;
	endfunction

	// Random gap before a request: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Send one sample pair and update the prediction when it is accepted.
	task automatic send_pair(logic [7:0] s, logic [7:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {d, s};
		do @(posedge clk); while (!s_tready);
		predict_pair(s, d);
		pairs_sent++;
	endtask

	// Let the block drain before a register write.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [swm_pkg::CFG_IDX_W-1:0] idx, int val);
		logic [swm_pkg::CFG_DAT_W-1:0] v;
		v = swm_pkg::CFG_DAT_W'(val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		predict_write(idx, v);
	endtask

	// Send count pairs following a content pattern.
	task automatic send_pattern(int count, pattern_t pat, int level);
		logic [7:0] s, d;
		for (int i = 0; i < count; i++) begin
			s = 8'($urandom_range(0, 255));
			case (pat)
				PAT_RANDOM: d = 8'($urandom_range(0, 255));
				PAT_SAME:   d = s;
				PAT_INVERT: d = ~s;
				PAT_NOISY: begin
					d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : s;
				end
				default: begin
					s = 8'(level);
					d = 8'(level) ^ 8'($urandom_range(0, 1));
				end
			endcase
			send_pair(s, d);
		end
	endtask

	// Flat frames at the sample extremes, then same and inverted frames, on the smallest window-sized frame.
	task automatic test_extremes();
		write_reg(swm_pkg::CFG_WIDTH, 8);
		write_reg(swm_pkg::CFG_HEIGHT, 8);
		repeat (64) send_pair(8'hFF, 8'h00);
		repeat (64) send_pair(8'h00, 8'hFF);
		repeat (64) send_pair(8'hFF, 8'hFF);
		repeat (64) send_pair(8'h00, 8'h00);
		send_pattern(64, PAT_SAME, 0);
		send_pattern(64, PAT_INVERT, 0);
	endtask

	// Values below and above the legal range are clamped by the block.
	task automatic test_clamping();
		write_reg(swm_pkg::CFG_WIDTH, 0);
		write_reg(swm_pkg::CFG_HEIGHT, 0);
		send_pattern(64, PAT_RANDOM, 0);
		write_reg(swm_pkg::CFG_WIDTH, 'h0FFF);
		write_reg(swm_pkg::CFG_HEIGHT, 'h1FFF);
		send_pattern(40, PAT_RANDOM, 0);
		write_reg(swm_pkg::CFG_WIDTH, 'h1008);
		send_pattern(80, PAT_NOISY, 0);
		write_reg(swm_pkg::CFG_HEIGHT, 7);
		send_pattern(64, PAT_RANDOM, 0);
	endtask

	// Writes to unused indexes must neither store anything nor restart the frame.
	task automatic test_spare_index();
		write_reg(swm_pkg::CFG_WIDTH, 9);
		write_reg(swm_pkg::CFG_HEIGHT, 9);
		send_pattern(40, PAT_RANDOM, 0);
		write_reg(CFG_SPARE_A, 'h1FFF);
		send_pattern(20, PAT_NOISY, 0);
		write_reg(CFG_SPARE_B, 'h0005);
		send_pattern(21, PAT_RANDOM, 0);
	endtask

	// The receiver holds off while a full frame keeps coming.
	task automatic test_backpressure();
		write_reg(swm_pkg::CFG_WIDTH, 10);
		write_reg(swm_pkg::CFG_HEIGHT, 9);
		no_gaps = 1'b1;
		hold_req++;
		send_pattern(90, PAT_NOISY, 0);
		no_gaps = 1'b0;
	endtask

	// Random small frames with random content, some cut short and some run on past the frame.
	task automatic test_random_frames();
		int w, h, count;
		while (pairs_sent < ITEM_COUNT) begin
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20) : $urandom_range(8, 12);
			h = $urandom_range(8, 11);
			write_reg(swm_pkg::CFG_WIDTH, w);
			write_reg(swm_pkg::CFG_HEIGHT, h);
			no_gaps = ($urandom_range(0, 3) == 0);
			count = w * h;
			if ($urandom_range(0, 5) == 0)
				count = $urandom_range(1, count);
			else if ($urandom_range(0, 3) == 0)
				count += w * $urandom_range(WIN, h);
			if (count > ITEM_COUNT - pairs_sent)
				count = ITEM_COUNT - pairs_sent;
			send_pattern(count, pattern_t'($urandom_range(0, 4)), $urandom_range(0, 255));
		end
		no_gaps = 1'b0;
	endtask

	// Receiver readiness: random stalls plus a long hold-off counted here when requested.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if ($urandom_range(0, 9) < 7) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		window_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_windows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: data=%h last=%b", m_tdata, m_tlast);
			end else begin
				want = pending_windows.pop_front();
				if (m_tdata[15:0] !== want.ssim || m_tdata[27:16] !== want.row ||
						m_tdata[38:28] !== want.col || m_tdata[54:39] !== want.mean ||
						m_tdata[55] !== 1'b0 || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected ssim=%0d row=%0d col=%0d last=%b mean=%0d, got ssim=%0d row=%0d col=%0d last=%b mean=%0d top=%b",
							want.ssim, want.row, want.col, want.last, want.mean,
							$signed(m_tdata[15:0]), m_tdata[27:16], m_tdata[38:28], m_tlast,
							$signed(m_tdata[54:39]), m_tdata[55]);
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#60ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		mismatches = 0;
		pairs_sent = 0;
		hold_req = 0;
		no_gaps = 1'b0;
		reg_width = swm_pkg::WIDTH_DEFAULT;
		reg_height = swm_pkg::HEIGHT_DEFAULT;
		at_row = 0;
		at_col = 0;
		frame_ssim_sum = 0;
		win_src = 0; win_dst = 0; win_src_sq = 0; win_dst_sq = 0; win_cross = 0;
		for (int i = 0; i < WIN * MAXW; i++)
			pair_store[i] = '0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= swm_pkg::CFG_WIDTH;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few pairs at the reset frame size; no window can close yet.
		send_pattern(12, PAT_RANDOM, 0);
		test_extremes();
		test_clamping();
		test_spare_index();
		test_backpressure();
		test_random_frames();

		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
sv/swm_pkg.sv
sv/swm_ram.sv
sv/ssim_window_metric.sv
sim/ssim_window_metric_tb.sv
